/* hdl/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, codes and helper functions for the inode state list table.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t ENTRIES_IDX = IDX_W'(ENTRIES);

  typedef enum logic [3:0] {
    REQ_WRITE          = 4'd0,
    REQ_MARK_DIRTY     = 4'd1,
    REQ_TRANSIT_START  = 4'd2,
    REQ_TRANSIT_END    = 4'd3,
    REQ_TO_DELETE      = 4'd4,
    REQ_DELETE         = 4'd5,
    REQ_ALLOCATE       = 4'd6,
    REQ_RECLAIM_ENTRY  = 4'd7,
    REQ_RECLAIM_FINISH = 4'd8
  } req_e;

  typedef enum logic [2:0] {
    ES_NONE  = 3'd0,
    ES_DIRTY = 3'd1,
    ES_TODEL = 3'd2,
    ES_PEND  = 3'd3,
    ES_FREE  = 3'd4
  } ent_e;

  typedef enum logic [1:0] {
    SC_OK        = 2'd0,
    SC_BAD_INDEX = 2'd1,
    SC_FULL      = 2'd2
  } sc_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_EVAL,
    CS_UNLINK,
    CS_APPEND,
    CS_ALLOC,
    CS_WB,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [3:0] req_type;
    idx_t       inode_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status_code;
    idx_t       result_index;
    logic [2:0] entry_state;
    logic       transit_now;
    logic       modified_in_transit;
    idx_t       dirty_head;
    idx_t       dirty_total;
    idx_t       active_total;
    idx_t       free_total;
    idx_t       pending_total;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic unlink;
    logic append;
    logic alloc;
    logic wb;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ent_ok;
    logic alloc_free;
    logic alloc_new;
    logic need_unl;
    logic need_app;
    logic out_free;
  } sts_t;

  function automatic logic in_table(idx_t x);
    return (x != '0) && (x <= ENTRIES_IDX);
  endfunction

  function automatic addr_t to_addr(idx_t x);
    idx_t t;
    t = x - idx_t'(1);
    return t[ADDR_W-1:0];
  endfunction

  function automatic idx_t inc_sat(idx_t v);
    return (v < ENTRIES_IDX) ? v + idx_t'(1) : v;
  endfunction

  function automatic idx_t dec_sat(idx_t v);
    return (v != '0) ? v - idx_t'(1) : v;
  endfunction

endpackage

/* hdl/isl_ctrl.sv */
// ----------------------------------------------------------------------------
// isl_ctrl
// Sequencer: steps one item through decode, list edits and write-back.
// ----------------------------------------------------------------------------
module isl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  isl_pkg::sts_t  sts_i,
  output isl_pkg::cmd_t  cmd_o
);

  isl_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isl_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      isl_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = isl_pkg::CS_DECODE;
        end
      end
      isl_pkg::CS_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.ent_ok) begin
          state_d = isl_pkg::CS_EVAL;
        end else if (sts_i.alloc_free) begin
          state_d = isl_pkg::CS_ALLOC;
        end else if (sts_i.alloc_new) begin
          state_d = isl_pkg::CS_WB;
        end else begin
          state_d = isl_pkg::CS_DONE;
        end
      end
      isl_pkg::CS_EVAL: begin
        if (sts_i.need_unl) begin
          state_d = isl_pkg::CS_UNLINK;
        end else if (sts_i.need_app) begin
          state_d = isl_pkg::CS_APPEND;
        end else begin
          state_d = isl_pkg::CS_WB;
        end
      end
      isl_pkg::CS_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = sts_i.need_app ? isl_pkg::CS_APPEND : isl_pkg::CS_WB;
      end
      isl_pkg::CS_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = isl_pkg::CS_WB;
      end
      isl_pkg::CS_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = isl_pkg::CS_WB;
      end
      isl_pkg::CS_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = isl_pkg::CS_DONE;
      end
      isl_pkg::CS_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = isl_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = isl_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

/* hdl/isl_dpath.sv */
// ----------------------------------------------------------------------------
// isl_dpath
// Entry table memories, list heads, tails, counters and the result register.
// ----------------------------------------------------------------------------
module isl_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  isl_pkg::cmd_t  cmd_i,
  output isl_pkg::sts_t  sts_o,
  input  isl_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output isl_pkg::rsp_t  out_data_o
);

  // entry table
  logic [2:0]      state_mem [isl_pkg::ENTRIES];
  logic            tr_mem    [isl_pkg::ENTRIES];
  logic            md_mem    [isl_pkg::ENTRIES];
  isl_pkg::idx_t   next_mem  [isl_pkg::ENTRIES];
  isl_pkg::idx_t   prev_mem  [isl_pkg::ENTRIES];

  logic [3:0]      req_q;
  isl_pkg::idx_t   idx_q, tgt_q, app_prev_q;
  logic [1:0]      status_q;
  logic            show_q;
  logic [2:0]      rd_st_q, ws_q;
  logic            rd_tr_q, rd_md_q, wt_q, wm_q;
  isl_pkg::idx_t   rd_nx_q, rd_pv_q;

  isl_pkg::idx_t   dirty_first_q, dirty_last_q, del_first_q, del_last_q;
  isl_pkg::idx_t   free_first_q, free_last_q;
  isl_pkg::idx_t   dirty_cnt_q, del_cnt_q, free_cnt_q, pend_cnt_q;
  isl_pkg::idx_t   alloc_cnt_q, active_cnt_q;
  logic            out_valid_q;
  isl_pkg::rsp_t   out_q;

  logic            ent_op, ent_ok, alloc_free, alloc_new, is_free;
  logic            need_unl, need_app, app_del, unl_del, reclaim_take;
  logic [2:0]      st_new;
  logic            tr_new, md_new;
  isl_pkg::idx_t   nx_new, pv_new, app_first, app_last;
  isl_pkg::addr_t  rd_addr, nx_waddr, pv_waddr, wb_addr;
  isl_pkg::idx_t   nx_wdata, pv_wdata;
  logic            nx_we, pv_we;

  // decode
  assign ent_op     = (req_q <= isl_pkg::REQ_DELETE) || (req_q == isl_pkg::REQ_RECLAIM_ENTRY);
  assign ent_ok     = ent_op && (idx_q != '0) && (idx_q <= alloc_cnt_q);
  assign alloc_free = (req_q == isl_pkg::REQ_ALLOCATE) && (free_cnt_q != '0) &&
                      isl_pkg::in_table(free_first_q);
  assign alloc_new  = (req_q == isl_pkg::REQ_ALLOCATE) && !alloc_free &&
                      (alloc_cnt_q < isl_pkg::ENTRIES_IDX);
  assign rd_addr    = ent_ok ? isl_pkg::to_addr(idx_q) : isl_pkg::to_addr(free_first_q);

  // per-request plan from the entry read
  assign is_free = (rd_st_q == isl_pkg::ES_FREE);
  assign unl_del = (rd_st_q == isl_pkg::ES_TODEL);

  always_comb begin
    need_unl     = 1'b0;
    need_app     = 1'b0;
    app_del      = 1'b0;
    reclaim_take = 1'b0;
    st_new       = rd_st_q;
    tr_new       = rd_tr_q;
    md_new       = rd_md_q;
    if (req_q == isl_pkg::REQ_RECLAIM_ENTRY) begin
      if (rd_st_q == isl_pkg::ES_PEND) begin
        st_new       = isl_pkg::ES_FREE;
        reclaim_take = 1'b1;
      end
    end else if (!is_free) begin
      case (req_q)
        isl_pkg::REQ_WRITE: begin
          need_unl = (rd_st_q == isl_pkg::ES_TODEL);
          need_app = (rd_st_q != isl_pkg::ES_DIRTY);
          st_new   = isl_pkg::ES_DIRTY;
          if (rd_tr_q) md_new = 1'b1;
        end
        isl_pkg::REQ_MARK_DIRTY: begin
          need_app = (rd_st_q == isl_pkg::ES_NONE);
          if (rd_st_q == isl_pkg::ES_NONE) st_new = isl_pkg::ES_DIRTY;
          if (rd_tr_q) md_new = 1'b1;
        end
        isl_pkg::REQ_TRANSIT_START: begin
          tr_new = 1'b1;
          md_new = 1'b0;
        end
        isl_pkg::REQ_TRANSIT_END: begin
          need_unl = (rd_st_q == isl_pkg::ES_DIRTY) && !rd_md_q;
          if (need_unl) st_new = isl_pkg::ES_NONE;
          tr_new = 1'b0;
          md_new = 1'b0;
        end
        isl_pkg::REQ_TO_DELETE: begin
          need_unl = (rd_st_q == isl_pkg::ES_DIRTY);
          need_app = (rd_st_q != isl_pkg::ES_TODEL);
          app_del  = 1'b1;
          st_new   = isl_pkg::ES_TODEL;
          tr_new   = 1'b0;
        end
        isl_pkg::REQ_DELETE: begin
          need_unl = (rd_st_q == isl_pkg::ES_DIRTY) || (rd_st_q == isl_pkg::ES_TODEL);
          st_new   = isl_pkg::ES_PEND;
          tr_new   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign nx_new    = (need_app || need_unl) ? '0 : (reclaim_take ? free_first_q : rd_nx_q);
  assign pv_new    = need_app ? app_prev_q : (need_unl ? '0 : rd_pv_q);
  assign app_first = app_del ? del_first_q : dirty_first_q;
  assign app_last  = app_del ? del_last_q : dirty_last_q;
  assign wb_addr   = isl_pkg::to_addr(tgt_q);

  // link memory write ports
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = wb_addr;
    nx_wdata = (req_q == isl_pkg::REQ_ALLOCATE) ? '0 : nx_new;
    pv_we    = 1'b0;
    pv_waddr = wb_addr;
    pv_wdata = (req_q == isl_pkg::REQ_ALLOCATE) ? '0 : pv_new;
    if (cmd_i.unlink) begin
      nx_we    = isl_pkg::in_table(rd_pv_q);
      nx_waddr = isl_pkg::to_addr(rd_pv_q);
      nx_wdata = rd_nx_q;
      pv_we    = isl_pkg::in_table(rd_nx_q);
      pv_waddr = isl_pkg::to_addr(rd_nx_q);
      pv_wdata = rd_pv_q;
    end else if (cmd_i.append) begin
      nx_we    = (app_first != '0) && isl_pkg::in_table(app_last);
      nx_waddr = isl_pkg::to_addr(app_last);
      nx_wdata = tgt_q;
    end else if (cmd_i.wb) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    if (pv_we) prev_mem[pv_waddr] <= pv_wdata;
    if (cmd_i.wb) begin
      state_mem[wb_addr] <= (req_q == isl_pkg::REQ_ALLOCATE) ? 3'(isl_pkg::ES_NONE) : st_new;
      tr_mem[wb_addr]    <= (req_q == isl_pkg::REQ_ALLOCATE) ? 1'b0 : tr_new;
      md_mem[wb_addr]    <= (req_q == isl_pkg::REQ_ALLOCATE) ? 1'b0 : md_new;
    end
    if (cmd_i.decode) begin
      rd_st_q <= state_mem[rd_addr];
      rd_tr_q <= tr_mem[rd_addr];
      rd_md_q <= md_mem[rd_addr];
      rd_nx_q <= next_mem[rd_addr];
      rd_pv_q <= prev_mem[rd_addr];
    end
  end

  // item payload and per-step values
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i.req_type;
      idx_q <= in_data_i.inode_index;
    end
    if (cmd_i.decode) begin
      show_q <= 1'b0;
      if (ent_op && !ent_ok) begin
        status_q <= isl_pkg::SC_BAD_INDEX;
      end else if ((req_q == isl_pkg::REQ_ALLOCATE) && !alloc_free && !alloc_new) begin
        status_q <= isl_pkg::SC_FULL;
      end else begin
        status_q <= isl_pkg::SC_OK;
      end
      if (ent_ok) begin
        tgt_q <= idx_q;
      end else if (alloc_new) begin
        tgt_q <= alloc_cnt_q + isl_pkg::idx_t'(1);
      end else begin
        tgt_q <= '0;
      end
    end
    if (cmd_i.alloc) tgt_q <= free_first_q;
    if (cmd_i.append) app_prev_q <= (app_first == '0) ? '0 : app_last;
    if (cmd_i.wb) begin
      show_q <= 1'b1;
      ws_q   <= (req_q == isl_pkg::REQ_ALLOCATE) ? 3'(isl_pkg::ES_NONE) : st_new;
      wt_q   <= (req_q == isl_pkg::REQ_ALLOCATE) ? 1'b0 : tr_new;
      wm_q   <= (req_q == isl_pkg::REQ_ALLOCATE) ? 1'b0 : md_new;
    end
    if (cmd_i.load_out) begin
      out_q.status_code         <= status_q;
      out_q.result_index        <= tgt_q;
      out_q.entry_state         <= show_q ? ws_q : '0;
      out_q.transit_now         <= show_q && wt_q;
      out_q.modified_in_transit <= show_q && wm_q;
      out_q.dirty_head          <= dirty_first_q;
      out_q.dirty_total         <= dirty_cnt_q;
      out_q.active_total        <= active_cnt_q;
      out_q.free_total          <= free_cnt_q;
      out_q.pending_total       <= pend_cnt_q;
    end
  end

  // list heads, tails and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_first_q <= '0;
      dirty_last_q  <= '0;
      del_first_q   <= '0;
      del_last_q    <= '0;
      free_first_q  <= '0;
      free_last_q   <= '0;
      dirty_cnt_q   <= '0;
      del_cnt_q     <= '0;
      free_cnt_q    <= '0;
      pend_cnt_q    <= '0;
      alloc_cnt_q   <= '0;
      active_cnt_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        if (alloc_new) alloc_cnt_q <= alloc_cnt_q + isl_pkg::idx_t'(1);
        if (req_q == isl_pkg::REQ_RECLAIM_FINISH) pend_cnt_q <= '0;
      end
      if (cmd_i.unlink) begin
        if (unl_del) begin
          if (rd_nx_q == '0) del_last_q <= rd_pv_q;
          if (rd_pv_q == '0) del_first_q <= rd_nx_q;
          del_cnt_q <= isl_pkg::dec_sat(del_cnt_q);
        end else begin
          if (rd_nx_q == '0) dirty_last_q <= rd_pv_q;
          if (rd_pv_q == '0) dirty_first_q <= rd_nx_q;
          dirty_cnt_q <= isl_pkg::dec_sat(dirty_cnt_q);
        end
      end
      if (cmd_i.append) begin
        if (app_del) begin
          if (del_first_q == '0) del_first_q <= tgt_q;
          del_last_q <= tgt_q;
          del_cnt_q  <= isl_pkg::inc_sat(del_cnt_q);
        end else begin
          if (dirty_first_q == '0) dirty_first_q <= tgt_q;
          dirty_last_q <= tgt_q;
          dirty_cnt_q  <= isl_pkg::inc_sat(dirty_cnt_q);
        end
      end
      if (cmd_i.alloc) begin
        if (rd_nx_q == '0) begin
          free_cnt_q   <= '0;
          free_first_q <= '0;
          free_last_q  <= '0;
        end else begin
          free_cnt_q   <= isl_pkg::dec_sat(free_cnt_q);
          free_first_q <= rd_nx_q;
        end
      end
      if (cmd_i.wb) begin
        if (req_q == isl_pkg::REQ_ALLOCATE) begin
          active_cnt_q <= isl_pkg::inc_sat(active_cnt_q);
        end else if (reclaim_take) begin
          if (free_last_q == '0) free_last_q <= tgt_q;
          free_first_q <= tgt_q;
          free_cnt_q   <= isl_pkg::inc_sat(free_cnt_q);
        end else if (!is_free && (req_q == isl_pkg::REQ_TO_DELETE)) begin
          active_cnt_q <= isl_pkg::dec_sat(active_cnt_q);
        end else if (!is_free && (req_q == isl_pkg::REQ_DELETE)) begin
          pend_cnt_q <= isl_pkg::inc_sat(pend_cnt_q);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.ent_ok     = ent_ok;
  assign sts_o.alloc_free = alloc_free;
  assign sts_o.alloc_new  = alloc_new;
  assign sts_o.need_unl   = need_unl;
  assign sts_o.need_app   = need_app;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_cnt_q <= isl_pkg::ENTRIES_IDX) && (active_cnt_q <= isl_pkg::ENTRIES_IDX) &&
    (dirty_cnt_q <= isl_pkg::ENTRIES_IDX) && (free_cnt_q <= isl_pkg::ENTRIES_IDX))
    else $error("counter beyond table size");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status_code != isl_pkg::SC_OK)) |->
    ((out_q.result_index == '0) && (out_q.entry_state == '0)))
    else $error("error item carries an index or entry state");

  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while stalled");

  a_alloc_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wb && (req_q == isl_pkg::REQ_ALLOCATE)) |-> (tgt_q != '0))
    else $error("allocate writes back to index zero");

endmodule

/* hdl/inode_state_list_table.sv */
// ----------------------------------------------------------------------------
// inode_state_list_table
// Inode entry table with dirty, to-delete and free lists kept in hardware.
// ----------------------------------------------------------------------------
// One request item enters on in_valid_i/in_ready_o (req_type, inode_index)
// and exactly one result item leaves on out_valid_o/out_ready_i. Items are
// worked one at a time by a sequencer over single-port entry memories:
// accept, decode with entry read, evaluation (entry requests), optional
// unlink, optional append or free-list pop, write-back and result load.
// The steps taken depend on the dependent table writes the request needs;
// a request that touches no entry goes from decode straight to the result
// load. The sequencer is ready for the next item in the cycle after the
// result load.
// A new item is accepted as soon as the previous result sits in the output
// register, so a result waiting on a stalled receiver does not block the
// next item's work; only the following result load waits for out_ready_i.
// Reset clears all list heads, tails and counters and empties the output
// register; the entry memories are not cleared, as an entry is always
// initialized on allocate before it can be addressed.
// ----------------------------------------------------------------------------
module inode_state_list_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  isl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isl_pkg::rsp_t out_data_o
);

  isl_pkg::cmd_t cmd;
  isl_pkg::sts_t sts;

  isl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  isl_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
